@@ hdl/min_gap_and_range_store_defines.svh @@
// Assertion helpers for the RTL of the minimum gap and range store.
`ifndef MIN_GAP_AND_RANGE_STORE_DEFINES_SVH
`define MIN_GAP_AND_RANGE_STORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MGRS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mgrs assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MGRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mgrs assertion failed");

`endif

@@ hdl/mgrs_pkg.sv @@
`default_nettype none

package mgrs_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CFG_W    = 11;
    localparam int DATA_W   = 32;

    localparam logic [DATA_W-1:0] SIGN_BIAS = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] ALL_ONES  = {DATA_W{1'b1}};

    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    localparam logic [1:0] STATUS_STORED  = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_CLEARED = 2'd2;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [CFG_W-1:0] stored_count;
        logic             spans_valid;
        logic [31:0]      min_gap;
        logic [31:0]      longest_span;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

@@ hdl/min_gap_and_range_store.sv @@
// A clear or a rejected add goes from acceptance straight to the finish state; an add
// with n values held does one memory read per held value, drains, commits and finishes.
// Throughput: one item at a time; in_stall is high from acceptance until the result is
// placed in the output register, so the value memory scan and out_stall set the rate.
// Reset (rst_n, asynchronous, active low) empties the set, sets capacity to 0 and the
// best gap to all ones; the value memory is not cleared and needs no clearing pass.
`default_nettype none

module min_gap_and_range_store
    import mgrs_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [CFG_W-1:0] cfg_wdata,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire in_item_t         in_item,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output out_item_t             out_item
);

`include "min_gap_and_range_store_defines.svh"

    // Values are held with the sign bit inverted, so that unsigned order is signed
    // order and every difference is an exact unsigned 32-bit number.
    logic [DATA_W-1:0] mem [CAPACITY];

    state_t state_reg, state_next;

    logic [CFG_W-1:0]  capacity_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [DATA_W-1:0] least_reg, least_next;
    logic [DATA_W-1:0] greatest_reg, greatest_next;
    logic [DATA_W-1:0] best_reg, best_next;
    logic [1:0]        status_reg, status_next;
    logic              rd_vld_reg, rd_vld_next;
    logic              dist_vld_reg, dist_vld_next;
    logic [DATA_W-1:0] rd_data_reg;
    logic [DATA_W-1:0] dist_reg;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_reg, out_next;

    logic              accept;
    logic [CNT_W-1:0]  limit;
    logic              full;
    logic              rd_issue;
    logic              mem_we;
    logic              out_free;
    logic [DATA_W-1:0] dist_val;

    // The block takes a new item only while the sequencer is idle; a result already
    // sitting in the output register does not hold the input side back.
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // The configured capacity saturates at the size of the value memory.
    always_comb
    begin
        if (32'(capacity_reg) > 32'(CAPACITY))
        begin
            limit = CNT_W'(CAPACITY);
        end
        else
        begin
            limit = CNT_W'(capacity_reg);
        end
    end

    assign full     = (cnt_reg >= limit);
    assign rd_issue = (state_reg == ST_SCAN) && (idx_reg < cnt_reg);
    assign mem_we   = (state_reg == ST_COMMIT);

    // Distance between the new value and one held value, registered before the
    // compare against the running best gap.
    assign dist_val = (val_reg > rd_data_reg) ? (val_reg - rd_data_reg)
                                              : (rd_data_reg - val_reg);

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_item.kind == KIND_CLEAR || full)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (!rd_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // Wait until the read and distance stages have emptied.
                if (!rd_vld_reg && !dist_vld_reg)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and output values driven by the sequencer.
    always_comb
    begin
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        val_next       = val_reg;
        least_next     = least_reg;
        greatest_next  = greatest_reg;
        best_next      = best_reg;
        status_next    = status_reg;
        rd_vld_next    = rd_issue;
        dist_vld_next  = rd_vld_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        // The running best gap is refreshed from the distance stage.
        if (dist_vld_reg && (dist_reg < best_reg))
        begin
            best_next = dist_reg;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    val_next = DATA_W'(in_item.value) ^ SIGN_BIAS;
                    idx_next = '0;
                    if (in_item.kind == KIND_CLEAR)
                    begin
                        cnt_next      = '0;
                        least_next    = '0;
                        greatest_next = '0;
                        best_next     = ALL_ONES;
                        status_next   = STATUS_CLEARED;
                    end
                    else if (full)
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        status_next = STATUS_STORED;
                    end
                end
            end
            ST_SCAN:
            begin
                if (rd_issue)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            ST_DRAIN:
            begin
            end
            ST_COMMIT:
            begin
                if (cnt_reg == '0)
                begin
                    least_next    = val_reg;
                    greatest_next = val_reg;
                end
                else
                begin
                    if (val_reg < least_reg)
                    begin
                        least_next = val_reg;
                    end
                    if (val_reg > greatest_reg)
                    begin
                        greatest_next = val_reg;
                    end
                end
                cnt_next = cnt_reg + CNT_W'(1);
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.status       = status_reg;
                    out_next.stored_count = CFG_W'(cnt_reg);
                    if (cnt_reg >= CNT_W'(2))
                    begin
                        out_next.spans_valid  = 1'b1;
                        out_next.min_gap      = best_reg;
                        out_next.longest_span = greatest_reg - least_reg;
                    end
                    else
                    begin
                        out_next.spans_valid  = 1'b0;
                        out_next.min_gap      = '0;
                        out_next.longest_span = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control state and the architectural registers of the set.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            capacity_reg  <= '0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            least_reg     <= '0;
            greatest_reg  <= '0;
            best_reg      <= ALL_ONES;
            status_reg    <= STATUS_STORED;
            rd_vld_reg    <= 1'b0;
            dist_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            least_reg     <= least_next;
            greatest_reg  <= greatest_next;
            best_reg      <= best_next;
            status_reg    <= status_next;
            rd_vld_reg    <= rd_vld_next;
            dist_vld_reg  <= dist_vld_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        dist_reg <= dist_val;
        out_reg  <= out_next;
    end

    // Value memory: one write port for the commit, one registered read port for the scan.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[cnt_reg[ADDR_W-1:0]] <= val_reg;
        end
        rd_data_reg <= mem[idx_reg[ADDR_W-1:0]];
    end

    `MGRS_ASSERT_SAME(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(CAPACITY))
    `MGRS_ASSERT_SAME(a_scan_bound, clk, rst_n, state_reg == ST_SCAN, idx_reg <= cnt_reg)
    `MGRS_ASSERT_NEXT(a_commit_count, clk, rst_n, state_reg == ST_COMMIT,
                      cnt_reg == $past(cnt_reg) + CNT_W'(1))
    `MGRS_ASSERT_SAME(a_order, clk, rst_n, cnt_reg >= CNT_W'(2), least_reg <= greatest_reg)
    `MGRS_ASSERT_NEXT(a_finish_hold, clk, rst_n,
                      state_reg == ST_FINISH && out_valid_reg && out_stall,
                      state_reg == ST_FINISH)

endmodule

`default_nettype wire

@@ tb/min_gap_and_range_store_test.sv @@
`timescale 1ns / 100ps

// Self-checking regression for the minimum gap and range store.
// Items are offered on the input channel and a software copy of the set
// predicts the report that each accepted item must produce. A checker
// process compares every accepted report, field by field, against the oldest
// prediction. Both channels idle at random in bursts, and one test holds the
// output off long enough that the block backs up and stalls its input.
module min_gap_and_range_store_test;
    import mgrs_pkg::*;

    localparam int PERIOD = 12;
    localparam int RESET_CYCLES = 9;
    // The timeout lies well above the longest possible run.
    localparam int TIMEOUT_CYCLES = 5_000_000;
    localparam int MAX_REPORTED = 10;
    localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    logic             in_valid;
    logic             in_stall;
    in_item_t         in_item;
    logic             out_valid;
    logic             out_stall;
    out_item_t        out_item;

    min_gap_and_range_store dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    // Software copy of the set. Values are kept with the sign bit flipped so
    // that unsigned comparison gives signed order and differences are exact.
    logic [DATA_W-1:0] set_values [CAPACITY];
    int unsigned       set_count;
    logic [DATA_W-1:0] set_least;
    logic [DATA_W-1:0] set_greatest;
    logic [DATA_W-1:0] set_best_gap;
    logic [CFG_W-1:0]  set_capacity;

    // Reports still owed by the block, oldest first.
    out_item_t pending_reports[$];

    int unsigned mismatches;
    int unsigned reports_checked;
    int unsigned items_sent;
    int unsigned values_stored;
    int unsigned adds_refused;
    int unsigned clears_done;
    int unsigned largest_set;

    // When set, both sides insert random idle bursts.
    bit          bursts_on;
    // A nonzero value asks the receiver for one long hold-off whose length this value sets.
    int unsigned hold_off_cycles;

    initial
    begin
        clk = 1'b0;
    end

    always #(PERIOD / 2) clk = ~clk;

    // Apply one item to the software set and return the report it must cause.
    function automatic out_item_t span_report_after(input in_item_t item);
        out_item_t         report;
        logic [DATA_W-1:0] biased;
        logic [DATA_W-1:0] diff;
        int unsigned       room;
        begin
            biased = item.value ^ SIGN_BIAS;
            // Capacities above the store depth saturate at the depth.
            room = (set_capacity > CAPACITY) ? CAPACITY : set_capacity;
            if (item.kind == KIND_CLEAR)
            begin
                set_count = 0;
                set_least = '0;
                set_greatest = '0;
                set_best_gap = ALL_ONES;
                report.status = STATUS_CLEARED;
                clears_done++;
            end
            else if (set_count >= room)
            begin
                // Covers a capacity lowered below the count: the set stays as it is.
                report.status = STATUS_FULL;
                adds_refused++;
            end
            else
            begin
                for (int i = 0; i < set_count; i++)
                begin
                    diff = (biased > set_values[i]) ? biased - set_values[i]
                                                    : set_values[i] - biased;
                    if (diff < set_best_gap)
                        set_best_gap = diff;
                end
                if (set_count == 0)
                begin
                    set_least = biased;
                    set_greatest = biased;
                end
                else
                begin
                    if (biased < set_least)
                        set_least = biased;
                    if (biased > set_greatest)
                        set_greatest = biased;
                end
                set_values[set_count] = biased;
                set_count++;
                report.status = STATUS_STORED;
                values_stored++;
                if (set_count > largest_set)
                    largest_set = set_count;
            end
            report.stored_count = set_count[CFG_W-1:0];
            // With fewer than two values both spans read as zero.
            if (set_count >= 2)
            begin
                report.spans_valid = 1'b1;
                report.min_gap = set_best_gap;
                report.longest_span = set_greatest - set_least;
            end
            else
            begin
                report.spans_valid = 1'b0;
                report.min_gap = '0;
                report.longest_span = '0;
            end
            return report;
        end
    endfunction

    // Offer one item and hold it until accepted. Valid stays high afterwards so
    // that back-to-back items follow with valid unbroken; a gap lowers it first.
    task automatic offer_item(input in_item_t item);
        int unsigned gap;
        begin
            if (bursts_on && $urandom_range(0, 2) == 0)
            begin
                gap = $urandom_range(1, 14);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid <= 1'b1;
            in_item <= item;
            do
                @(posedge clk);
            while (in_stall);
            pending_reports.push_back(span_report_after(item));
            items_sent++;
        end
    endtask

    task automatic add_value(input logic signed [31:0] value);
        in_item_t item;
        begin
            item.kind = KIND_ADD;
            item.value = value;
            offer_item(item);
        end
    endtask

    // The value field of a clear carries noise; the block must ignore it.
    task automatic clear_set();
        in_item_t item;
        begin
            item.kind = KIND_CLEAR;
            item.value = $urandom;
            offer_item(item);
        end
    endtask

    // Stop offering and wait until every report has come back, then give the
    // block a chance to show any report it should not produce.
    task automatic drain_reports();
        begin
            in_valid <= 1'b0;
            while (pending_reports.size() != 0)
                @(posedge clk);
            repeat (8) @(posedge clk);
        end
    endtask

    // The capacity register is only written while the block is idle.
    task automatic write_capacity(input int unsigned capacity);
        begin
            drain_reports();
            cfg_we <= 1'b1;
            cfg_wdata <= capacity[CFG_W-1:0];
            @(posedge clk);
            set_capacity = capacity[CFG_W-1:0];
            cfg_we <= 1'b0;
        end
    endtask

    // Draw a value in one of several styles. Clustered values around a base
    // give small gaps; the extremes stress the full unsigned 32-bit difference.
    function automatic logic signed [31:0] draw_value(input int unsigned style,
                                                      input logic signed [31:0] base);
        logic signed [31:0] edges [7];
        begin
            edges = '{INT_MIN, INT_MIN + 1, INT_MAX, INT_MAX - 1, 0, -1, 1};
            case (style)
                0: return $urandom;
                1: return base + $signed($urandom_range(0, 64)) - 32;
                2: return edges[$urandom_range(0, 6)];
                default: return $signed($urandom_range(0, 200)) - 100;
            endcase
        end
    endfunction

    // After reset the capacity is zero, so every add is refused.
    task automatic test_reset_state();
        begin
            add_value(5);
            clear_set();
            drain_reports();
        end
    endtask

    // The widest possible spans, a single value, a duplicate and a refusal.
    task automatic test_extreme_values();
        begin
            write_capacity(3);
            add_value(INT_MIN);
            add_value(INT_MAX);
            add_value(-1);
            add_value(7);
            clear_set();
            add_value(42);
            add_value(42);
            drain_reports();
        end
    endtask

    // Lowering the capacity below the count keeps the set but refuses adds
    // until a clear empties it.
    task automatic test_capacity_lowered();
        begin
            write_capacity(4);
            clear_set();
            add_value(10);
            add_value(-10);
            add_value(3);
            write_capacity(2);
            add_value(5);
            clear_set();
            add_value(1);
            drain_reports();
        end
    endtask

    // The top register value, then the store depth itself.
    task automatic test_capacity_limits();
        begin
            write_capacity(2047);
            clear_set();
            add_value(100);
            add_value(200);
            add_value(-300);
            write_capacity(CAPACITY);
            add_value(0);
            drain_reports();
        end
    endtask

    // Hold the output off for a long stretch while items keep coming, so the
    // output register fills and the block stalls its input.
    task automatic test_output_backpressure();
        bit saved;
        begin
            saved = bursts_on;
            bursts_on = 1'b0;
            write_capacity(CAPACITY);
            hold_off_cycles = 300;
            for (int k = 0; k < 12; k++)
                add_value($urandom);
            drain_reports();
            bursts_on = saved;
        end
    endtask

    // Random sets: each one sets a capacity, usually starts from empty and
    // fills a capacity up to 40 to or just past it, larger ones in part, with
    // values of one style. A few stray clears and carried-on sets add noise.
    task automatic test_random_sets(input int unsigned budget);
        int unsigned        sent;
        int unsigned        capacity;
        int unsigned        adds;
        int unsigned        style;
        logic signed [31:0] base;
        begin
            sent = 0;
            while (sent < budget)
            begin
                case ($urandom_range(0, 9))
                    0: capacity = 0;
                    1: capacity = 1;
                    2: capacity = 2;
                    3: capacity = CAPACITY;
                    4: capacity = 2047;
                    5: capacity = $urandom_range(0, 2047);
                    default: capacity = $urandom_range(3, 24);
                endcase
                write_capacity(capacity);
                if ($urandom_range(0, 4) != 0)
                begin
                    clear_set();
                    sent++;
                end
                if (capacity <= 40)
                    adds = capacity + $urandom_range(0, 2);
                else if ($urandom_range(0, 5) == 0)
                    adds = $urandom_range(60, 120);
                else
                    adds = $urandom_range(8, 40);
                style = $urandom_range(0, 3);
                base = $urandom;
                for (int k = 0; k < adds; k++)
                begin
                    if ($urandom_range(0, 29) == 0)
                        clear_set();
                    else
                        add_value(draw_value(style, base));
                    sent++;
                end
            end
            drain_reports();
        end
    endtask

    // Closing stretch with no idling on either side.
    task automatic test_steady_stream();
        begin
            bursts_on = 1'b0;
            write_capacity(16);
            clear_set();
            for (int k = 0; k < 40; k++)
            begin
                if ($urandom_range(0, 11) == 0)
                    clear_set();
                else
                    add_value(draw_value($urandom_range(0, 3), $urandom));
            end
            drain_reports();
        end
    endtask

    // Receiver: random stall bursts, and the one long hold-off on request.
    initial
    begin
        int unsigned burst;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_off_cycles) @(posedge clk);
                out_stall <= 1'b0;
                hold_off_cycles = 0;
            end
            else if (bursts_on && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 14);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic log_mismatch(input string why, input out_item_t want, input out_item_t got);
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTED)
            begin
                $display("%0t: %s", $realtime, why);
                $display("    expected status %0d count %0d valid %0b short %h long %h",
                         want.status, want.stored_count, want.spans_valid,
                         want.min_gap, want.longest_span);
                $display("    actual   status %0d count %0d valid %0b short %h long %h",
                         got.status, got.stored_count, got.spans_valid,
                         got.min_gap, got.longest_span);
            end
        end
    endtask

    // Checker: every report taken from the block is matched to the oldest
    // prediction. Inputs are driven with nonblocking assignments, so the
    // values read here are the ones present at the edge.
    always @(posedge clk)
    begin : check_reports
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            reports_checked++;
            if (pending_reports.size() == 0)
            begin
                want = '0;
                log_mismatch("report with no item waiting for it", want, out_item);
            end
            else
            begin
                want = pending_reports.pop_front();
                if (out_item.status !== want.status
                    || out_item.stored_count !== want.stored_count
                    || out_item.spans_valid !== want.spans_valid
                    || out_item.min_gap !== want.min_gap
                    || out_item.longest_span !== want.longest_span)
                    log_mismatch("report differs from prediction", want, out_item);
            end
        end
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #(PERIOD * TIMEOUT_CYCLES);
        $display("timed out with %0d reports outstanding", pending_reports.size());
        $display("min_gap_and_range_store regression: fail");
        $finish;
    end

    // Main sequence: reset once, then each test in turn.
    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        in_valid <= 1'b0;
        in_item <= '0;
        mismatches = 0;
        reports_checked = 0;
        items_sent = 0;
        values_stored = 0;
        adds_refused = 0;
        clears_done = 0;
        largest_set = 0;
        hold_off_cycles = 0;
        bursts_on = 1'b0;
        set_count = 0;
        set_least = '0;
        set_greatest = '0;
        set_best_gap = ALL_ONES;
        set_capacity = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        bursts_on = 1'b1;
        test_reset_state();
        test_extreme_values();
        test_capacity_lowered();
        test_capacity_limits();
        test_output_backpressure();
        test_random_sets(520);
        test_steady_stream();

        // The last drain already waited past the longest latency of an idle block.
        repeat (20) @(posedge clk);
        $display("%0d items sent: %0d values stored, %0d adds refused, %0d clears",
                 items_sent, values_stored, adds_refused, clears_done);
        $display("largest set %0d values, %0d reports checked, %0d mismatches",
                 largest_set, reports_checked, mismatches);
        if (mismatches == 0 && pending_reports.size() == 0)
            $display("min_gap_and_range_store regression: pass");
        else
            $display("min_gap_and_range_store regression: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/mgrs_pkg.sv
hdl/min_gap_and_range_store.sv
tb/min_gap_and_range_store_test.sv
